/* sv/swmd_pkg.sv */
// shared widths and request/status codes for the stack with middle delete
package swmd_pkg;

    // payload widths
    localparam int unsigned VALUE_W       = 32;
    localparam int unsigned REQ_W         = 2;
    localparam int unsigned STATUS_W      = 2;
    localparam int unsigned ENTRY_COUNT_W = 7;

    typedef logic [REQ_W-1:0]    req_code_t;
    typedef logic [STATUS_W-1:0] status_code_t;

    // request codes
    localparam req_code_t REQ_PUSH    = 2'd0;
    localparam req_code_t REQ_POP     = 2'd1;
    localparam req_code_t REQ_DEL_MID = 2'd2;

    // status codes
    localparam status_code_t STATUS_OK        = 2'd0;
    localparam status_code_t STATUS_OVERFLOW  = 2'd1;
    localparam status_code_t STATUS_UNDERFLOW = 2'd2;

endpackage

/* sv/swmd_req_if.sv */
// request channel: one word carries a request code and a push value
interface swmd_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [swmd_pkg::REQ_W-1:0]           req_type;
    logic signed [swmd_pkg::VALUE_W-1:0]  push_value;

    modport source (output valid, output req_type, output push_value, input ready);
    modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

/* sv/swmd_rsp_if.sv */
// response channel: one word per request with status, top and count
interface swmd_rsp_if;
    logic                                      valid;
    logic                                      ready;
    logic [swmd_pkg::STATUS_W-1:0]             status;
    logic signed [swmd_pkg::VALUE_W-1:0]       top_value;
    logic                                      top_valid;
    logic [swmd_pkg::ENTRY_COUNT_W-1:0]        entry_count;

    modport source (output valid, output status, output top_value, output top_valid,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input top_value, input top_valid,
                    input entry_count, output ready);
endinterface

/* sv/stack_with_middle_delete.sv */
// Bounded stack of signed 32-bit values with push, pop and delete-middle requests. The entries
// live in one synchronous memory (one write port, one registered read port); the top value is
// kept in a register. Each request word returns exactly one response word. Push, failed requests,
// the unused code and a request that empties the stack go straight to the finish state; pop on
// two or more entries and delete on two entries read the memory once to fetch the new top;
// delete-middle on n >= 3 entries moves n - 1 - floor(n/2) entries down one place, one memory
// read/write per cycle. A new request is taken while the previous response still waits in
// the output register. Delete-middle removes the entry at index floor(n/2) counted from the
// bottom. entry_count carries the low 7 bits of the count.
module stack_with_middle_delete #(
    parameter int unsigned STACK_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    swmd_req_if.sink    req,
    swmd_rsp_if.source  rsp
);

    localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_READ   = 4'b0010,
        S_SHIFT  = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    // control and item state
    state_t                             state_reg, state_next;
    logic [CW-1:0]                      count_reg, count_next;
    logic [AW-1:0]                      ptr_reg, ptr_next;
    logic signed [swmd_pkg::VALUE_W-1:0] top_reg, top_next;
    swmd_pkg::status_code_t             status_reg, status_next;

    // output register
    logic                                  out_valid_reg, out_valid_next;
    swmd_pkg::status_code_t                out_status_reg, out_status_next;
    logic signed [swmd_pkg::VALUE_W-1:0]   out_top_reg, out_top_next;
    logic                                  out_top_valid_reg, out_top_valid_next;
    logic [swmd_pkg::ENTRY_COUNT_W-1:0]    out_count_reg, out_count_next;

    // memory
    logic [swmd_pkg::VALUE_W-1:0] stack_mem [STACK_DEPTH];
    logic [swmd_pkg::VALUE_W-1:0] mem_rdata_reg;
    logic                         mem_we;
    logic [AW-1:0]                mem_waddr;
    logic [AW-1:0]                mem_raddr;
    logic [swmd_pkg::VALUE_W-1:0] mem_wdata;

    logic req_fire;
    logic out_free;
    logic full;
    logic empty;

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign full      = (count_reg == CW'(STACK_DEPTH));
    assign empty     = (count_reg == '0);

    // request sequencing and memory access control
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        top_next    = top_reg;
        status_next = status_reg;
        mem_we      = 1'b0;
        mem_waddr   = ptr_reg - AW'(1);
        mem_wdata   = mem_rdata_reg;
        mem_raddr   = ptr_reg + AW'(1);

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    status_next = swmd_pkg::STATUS_OK;
                    state_next  = S_FINISH;
                    case (req.req_type)
                        swmd_pkg::REQ_PUSH:
                        begin
                            if (full)
                            begin
                                status_next = swmd_pkg::STATUS_OVERFLOW;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = AW'(count_reg);
                                mem_wdata  = req.push_value;
                                top_next   = req.push_value;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        swmd_pkg::REQ_POP, swmd_pkg::REQ_DEL_MID:
                        begin
                            if (empty)
                            begin
                                status_next = swmd_pkg::STATUS_UNDERFLOW;
                            end
                            else if (req.req_type == swmd_pkg::REQ_DEL_MID &&
                                     count_reg > CW'(2))
                            begin
                                // middle entry at floor(n/2); move the ones above it down
                                count_next = count_reg - CW'(1);
                                mem_raddr  = AW'((count_reg >> 1) + CW'(1));
                                ptr_next   = AW'((count_reg >> 1) + CW'(1));
                                state_next = S_SHIFT;
                            end
                            else
                            begin
                                // top removed: fetch the entry below it
                                count_next = count_reg - CW'(1);
                                mem_raddr  = AW'(count_reg - CW'(2));
                                if (count_reg > CW'(1))
                                begin
                                    state_next = S_READ;
                                end
                            end
                        end
                        default:
                        begin
                            status_next = swmd_pkg::STATUS_OK;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                top_next   = mem_rdata_reg;
                state_next = S_FINISH;
            end
            S_SHIFT:
            begin
                // write the word read last cycle one place lower
                mem_we = 1'b1;
                if (CW'(ptr_reg) == count_reg)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    ptr_next = ptr_reg + AW'(1);
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // response word loading
    always_comb
    begin
        out_valid_next     = out_valid_reg;
        out_status_next    = out_status_reg;
        out_top_next       = out_top_reg;
        out_top_valid_next = out_top_valid_reg;
        out_count_next     = out_count_reg;
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (state_reg == S_FINISH && out_free)
        begin
            out_valid_next     = 1'b1;
            out_status_next    = status_reg;
            out_top_next       = empty ? '0 : top_reg;
            out_top_valid_next = !empty;
            out_count_next     = swmd_pkg::ENTRY_COUNT_W'(count_reg);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ptr_reg           <= ptr_next;
        top_reg           <= top_next;
        status_reg        <= status_next;
        out_status_reg    <= out_status_next;
        out_top_reg       <= out_top_next;
        out_top_valid_reg <= out_top_valid_next;
        out_count_reg     <= out_count_next;
    end

    // stack memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= stack_mem[mem_raddr];
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.top_value   = out_top_reg;
    assign rsp.top_valid   = out_top_valid_reg;
    assign rsp.entry_count = out_count_reg;

`ifndef NO_ASSERTIONS
    // count never passes the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("entry count above depth");

    // shift pointer stays inside the held entries
    a_shift_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SHIFT |-> (ptr_reg != '0 && CW'(ptr_reg) <= count_reg))
        else $error("shift pointer out of range");

    // a successful push adds exactly one entry
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && req.req_type == swmd_pkg::REQ_PUSH && !full)
        |=> count_reg == $past(count_reg) + CW'(1))
        else $error("push did not add one entry");
`endif

endmodule

/* tb/swmd_stack_check.sv */
// result checker for the stack with middle delete: shadow stack, expected words and compare
module swmd_stack_check #(
    parameter int unsigned STACK_DEPTH = 64
) (
    input  logic clk,
    input  logic rst_n,
    swmd_req_if  req,
    swmd_rsp_if  rsp,
    output int   mismatches,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        swmd_pkg::status_code_t                    status;
        logic signed [swmd_pkg::VALUE_W-1:0]       top_value;
        logic                                      top_valid;
        logic [swmd_pkg::ENTRY_COUNT_W-1:0]        entry_count;
    } stack_reply_t;

    // shadow copy of the stack, index 0 at the bottom
    logic signed [swmd_pkg::VALUE_W-1:0] shadow_stack [STACK_DEPTH];
    int unsigned                         shadow_fill;
    stack_reply_t                        replies_due [$];
    int                                  fault_total;

    // apply one request word to the shadow stack and return the reply it earns
    function automatic stack_reply_t apply_request(swmd_pkg::req_code_t code,
                                                   logic signed [swmd_pkg::VALUE_W-1:0] value);
        stack_reply_t reply;
        int unsigned  n;
        int unsigned  k;
        int unsigned  gone;
        reply.status = swmd_pkg::STATUS_OK;
        case (code)
            swmd_pkg::REQ_PUSH:
            begin
                if (shadow_fill >= STACK_DEPTH)
                    reply.status = swmd_pkg::STATUS_OVERFLOW;
                else
                begin
                    shadow_stack[shadow_fill] = value;
                    shadow_fill++;
                end
            end
            swmd_pkg::REQ_POP:
            begin
                if (shadow_fill == 0)
                    reply.status = swmd_pkg::STATUS_UNDERFLOW;
                else
                    shadow_fill--;
            end
            swmd_pkg::REQ_DEL_MID:
            begin
                if (shadow_fill == 0)
                    reply.status = swmd_pkg::STATUS_UNDERFLOW;
                else
                begin
                    // k counts from the top; entries above the removed one slide down
                    n    = shadow_fill;
                    k    = (n % 2 == 0) ? (n / 2 - 1) : (n / 2);
                    gone = n - 1 - k;
                    for (int unsigned i = gone; i + 1 < n; i++)
                        shadow_stack[i] = shadow_stack[i + 1];
                    shadow_fill--;
                end
            end
            default:
            begin
                // unused code leaves the stack alone
            end
        endcase
        if (shadow_fill > 0)
        begin
            reply.top_value = shadow_stack[shadow_fill - 1];
            reply.top_valid = 1'b1;
        end
        else
        begin
            reply.top_value = '0;
            reply.top_valid = 1'b0;
        end
        reply.entry_count = shadow_fill[swmd_pkg::ENTRY_COUNT_W-1:0];
        return reply;
    endfunction

    // compare returned words first, then predict the word accepted at this edge
    always @(posedge clk or negedge rst_n)
    begin
        stack_reply_t want;
        if (!rst_n)
        begin
            shadow_fill = 0;
            fault_total = 0;
            replies_due.delete();
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (replies_due.size() == 0)
                begin
                    fault_total++;
                    $display("%0t: response word with nothing expected, status %0d top %0d",
                             $realtime, rsp.status, rsp.top_value);
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        fault_total++;
                        $display("%0t: status expected %0d actual %0d",
                                 $realtime, want.status, rsp.status);
                    end
                    if (rsp.top_value !== want.top_value)
                    begin
                        fault_total++;
                        $display("%0t: top_value expected %0d actual %0d",
                                 $realtime, want.top_value, rsp.top_value);
                    end
                    if (rsp.top_valid !== want.top_valid)
                    begin
                        fault_total++;
                        $display("%0t: top_valid expected %0d actual %0d",
                                 $realtime, want.top_valid, rsp.top_valid);
                    end
                    if (rsp.entry_count !== want.entry_count)
                    begin
                        fault_total++;
                        $display("%0t: entry_count expected %0d actual %0d",
                                 $realtime, want.entry_count, rsp.entry_count);
                    end
                end
            end
            if (req.valid && req.ready)
                replies_due.push_back(apply_request(req.req_type, req.push_value));
            mismatches <= fault_total;
            pending    <= replies_due.size();
        end
    end

endmodule

/* tb/stack_with_middle_delete_tb.sv */
// top of the stack with middle delete testbench: clock, reset, request and response traffic
module stack_with_middle_delete_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEPTH       = 64;
    localparam int          RANDOM_REQS = 1530;
    localparam int          HOLD_CYCLES = 400;
    localparam int          DRAIN_WAIT  = 48;

    // request code the block ignores
    localparam swmd_pkg::req_code_t REQ_UNUSED = 2'd3;

    // request mixes for the random segments
    localparam int MIX_FILL  = 0;
    localparam int MIX_DRAIN = 1;
    localparam int MIX_BLEND = 2;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   mismatches;
    int   pending;
    bit   tx_calm = 1'b0;
    bit   rx_calm = 1'b0;
    bit   hold_off_due = 1'b0;

    swmd_req_if req_if ();
    swmd_rsp_if rsp_if ();

    stack_with_middle_delete #(.STACK_DEPTH(DEPTH)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    swmd_stack_check #(.STACK_DEPTH(DEPTH)) u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_if),
        .rsp        (rsp_if),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // offer one request word and return at the edge that takes it
    task automatic offer_request(swmd_pkg::req_code_t code,
                                 logic signed [swmd_pkg::VALUE_W-1:0] value);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.req_type   <= code;
        req_if.push_value <= value;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
    endtask

    // response side: random stalls, calm stretches and the odd long hold-off
    initial
    begin
        int gap;
        int rx_words;
        rx_words = 0;
        rsp_if.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            if (hold_off_due)
            begin
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_due = 1'b0;
            end
            gap = rx_calm ? 0 : $urandom_range(0, 7);
            if (gap > 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_if.valid) @(posedge clk);
            rx_words++;
            if (rx_words % 64 == 0)
                rx_calm = ($urandom_range(0, 3) == 0);
        end
    end

    // stimulus and verdict
    initial
    begin
        int                                  sent;
        int                                  seg_len;
        int                                  mix;
        int                                  pick;
        int                                  segments;
        swmd_pkg::req_code_t                 code;
        logic signed [swmd_pkg::VALUE_W-1:0] value;

        req_if.valid      = 1'b0;
        req_if.req_type   = swmd_pkg::REQ_PUSH;
        req_if.push_value = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty stack, extremes, delete on one, two, three and four entries
        offer_request(swmd_pkg::REQ_POP, 32'sd0);
        offer_request(swmd_pkg::REQ_DEL_MID, 32'sd0);
        offer_request(REQ_UNUSED, 32'sd7);
        offer_request(swmd_pkg::REQ_PUSH, 32'sh7FFF_FFFF);
        offer_request(swmd_pkg::REQ_DEL_MID, 32'sd0);
        offer_request(swmd_pkg::REQ_PUSH, 32'sh8000_0000);
        offer_request(swmd_pkg::REQ_PUSH, -32'sd1);
        offer_request(swmd_pkg::REQ_DEL_MID, 32'sd0);
        offer_request(swmd_pkg::REQ_PUSH, 32'sd0);
        offer_request(swmd_pkg::REQ_PUSH, 32'sh5555_5555);
        offer_request(swmd_pkg::REQ_DEL_MID, 32'sd0);
        offer_request(swmd_pkg::REQ_PUSH, 32'shAAAA_AAAA);
        offer_request(swmd_pkg::REQ_PUSH, 32'sd12);
        offer_request(swmd_pkg::REQ_DEL_MID, 32'sd0);
        offer_request(REQ_UNUSED, -32'sd1);
        offer_request(swmd_pkg::REQ_POP, 32'sd0);
        offer_request(swmd_pkg::REQ_POP, 32'sd0);
        offer_request(swmd_pkg::REQ_POP, 32'sd0);
        offer_request(swmd_pkg::REQ_POP, 32'sd0);
        offer_request(swmd_pkg::REQ_DEL_MID, 32'sd0);

        // random segments, each leaning towards filling, draining or neither
        sent = 0;
        segments = 0;
        while (sent < RANDOM_REQS)
        begin
            mix     = $urandom_range(MIX_FILL, MIX_BLEND);
            seg_len = $urandom_range(20, 90);
            tx_calm = ($urandom_range(0, 3) == 0);
            segments++;
            // long hold-offs on the response side while filling
            if (segments == 4 || segments == 20)
            begin
                mix          = MIX_FILL;
                hold_off_due = 1'b1;
            end
            for (int i = 0; i < seg_len && sent < RANDOM_REQS; i++)
            begin
                pick = $urandom_range(0, 99);
                case (mix)
                    MIX_FILL:
                        code = (pick < 75) ? swmd_pkg::REQ_PUSH :
                               (pick < 85) ? swmd_pkg::REQ_POP :
                               (pick < 97) ? swmd_pkg::REQ_DEL_MID : REQ_UNUSED;
                    MIX_DRAIN:
                        code = (pick < 15) ? swmd_pkg::REQ_PUSH :
                               (pick < 50) ? swmd_pkg::REQ_POP :
                               (pick < 97) ? swmd_pkg::REQ_DEL_MID : REQ_UNUSED;
                    default:
                        code = (pick < 45) ? swmd_pkg::REQ_PUSH :
                               (pick < 65) ? swmd_pkg::REQ_POP :
                               (pick < 97) ? swmd_pkg::REQ_DEL_MID : REQ_UNUSED;
                endcase
                case ($urandom_range(0, 9))
                    0:       value = 32'sh8000_0000;
                    1:       value = 32'sh7FFF_FFFF;
                    2:       value = 32'sd0;
                    3:       value = -32'sd1;
                    default: value = $urandom;
                endcase
                offer_request(code, value);
                sent++;
            end
        end
        req_if.valid <= 1'b0;
        tx_calm = 1'b0;

        // let the last responses come back and any straggler show up
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("stack_with_middle_delete test passed");
        else
            $display("stack_with_middle_delete test failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #1_000_000;
        $display("stack_with_middle_delete test failed");
        $finish;
    end

endmodule
